### rtl/core/sca_pkg.sv
// ----------------------------------------------------------------------------
// sca_pkg
// Types, codes and class tables shared by the size-class allocator modules.
// ----------------------------------------------------------------------------
`default_nettype none

package sca_pkg;

    localparam int CLS_MAX = 8;
    localparam int CLS_W   = 3;

    // Port field widths
    localparam int SIZE_W     = 32;
    localparam int PORT_HDL_W = 16;
    localparam int PORT_USE_W = 17;
    localparam int KB_W       = 32;

    localparam logic [KB_W-1:0] LIMIT_RST = 32'd4194304;

    // Class size in KB and preallocated handles per class
    localparam logic [31:0] CLASS_KB [CLS_MAX] = '{
        32'd4, 32'd16, 32'd64, 32'd256, 32'd1024, 32'd4096, 32'd8192, 32'd16384
    };
    localparam logic [31:0] CLASS_PRE [CLS_MAX] = '{
        32'd5000, 32'd1000, 32'd500, 32'd200, 32'd50, 32'd20, 32'd10, 32'd0
    };

    typedef enum logic {
        FUNC_ALLOC = 1'b0,
        FUNC_REL   = 1'b1
    } func_t;

    typedef enum logic [2:0] {
        ST_OK        = 3'd0,
        ST_TOO_LARGE = 3'd1,
        ST_LIMIT     = 3'd2,
        ST_UNKNOWN   = 3'd3,
        ST_EXHAUSTED = 3'd4
    } status_t;

    typedef enum logic [1:0] {
        S_IDLE,
        S_DECIDE,
        S_POP
    } ctrl_state_t;

    typedef struct packed {
        logic capture;   // latch the incoming request
        logic exec;      // decide and update class state
        logic load_pop;  // finish a pop with the memory read data
    } ctrl_cmd_t;

    typedef struct packed {
        logic is_pop;    // the decision pops a free stack
        logic out_free;  // the result register can take a new result
    } dp_stat_t;

    // Preallocated pool size in KB, with counts clipped to the handle space
    function automatic logic [KB_W-1:0] pool_kb(input int num_cls, input int hbits);
        logic [31:0] acc;
        logic [31:0] pre;
        logic [31:0] hspace;
        acc    = '0;
        hspace = 32'd1 << hbits;
        for (int c = 0; c < CLS_MAX; c++)
        begin
            if (c < num_cls)
            begin
                pre = (CLASS_PRE[c] > hspace) ? hspace : CLASS_PRE[c];
                acc = acc + pre * CLASS_KB[c];
            end
        end
        return acc;
    endfunction

endpackage

`default_nettype wire

### rtl/core/sca_ctrl.sv
// ----------------------------------------------------------------------------
// sca_ctrl
// Sequencer: takes a request, lets the datapath decide, waits out a stack pop.
// ----------------------------------------------------------------------------
`default_nettype none

module sca_ctrl
    import sca_pkg::*;
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire logic      s_tvalid,
    output logic           s_tready,
    output ctrl_cmd_t      cmd,
    input  wire dp_stat_t  stat
);

    ctrl_state_t state_reg;
    ctrl_state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_IDLE;
        else
            state_reg <= state_next;
    end

    always_comb
    begin
        state_next = state_reg;
        s_tready   = 1'b0;
        cmd        = '0;
        unique case (state_reg)
            S_IDLE:
            begin
                s_tready = 1'b1;
                if (s_tvalid)
                begin
                    cmd.capture = 1'b1;
                    state_next  = S_DECIDE;
                end
            end
            S_DECIDE:
            begin
                // hold until the result register has room
                if (stat.out_free)
                begin
                    cmd.exec   = 1'b1;
                    state_next = stat.is_pop ? S_POP : S_IDLE;
                end
            end
            S_POP:
            begin
                if (stat.out_free)
                begin
                    cmd.load_pop = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

### rtl/core/sca_datapath.sv
// ----------------------------------------------------------------------------
// sca_datapath
// Class selection, per-class counters, free stack memory and result register.
// ----------------------------------------------------------------------------
`default_nettype none

module sca_datapath
    import sca_pkg::*;
#(
    parameter int NUM_CLASSES = 7,
    parameter int HANDLE_BITS = 16
)
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire ctrl_cmd_t             cmd,
    output dp_stat_t                   stat,
    input  wire logic                  cfg_we,
    input  wire logic [KB_W-1:0]       cfg_wdata,
    input  wire logic                  in_func,
    input  wire logic [SIZE_W-1:0]     in_size,
    input  wire logic [CLS_W-1:0]      in_class,
    input  wire logic [PORT_HDL_W-1:0] in_handle,
    output logic                       out_valid,
    input  wire logic                  out_ready,
    output status_t                    out_status,
    output logic [CLS_W-1:0]           out_class,
    output logic [PORT_HDL_W-1:0]      out_handle,
    output logic [PORT_USE_W-1:0]      out_in_use,
    output logic [KB_W-1:0]            out_total
);

    localparam int CNT_W  = HANDLE_BITS + 1;
    localparam int IU_W   = HANDLE_BITS + 2;
    localparam int CLS_AW = (NUM_CLASSES > 1) ? $clog2(NUM_CLASSES) : 1;
    localparam int MEM_AW = CLS_AW + HANDLE_BITS;
    localparam int MEM_DEPTH = NUM_CLASSES << HANDLE_BITS;
    localparam logic [CNT_W-1:0] HSPACE   = CNT_W'(1) << HANDLE_BITS;
    localparam logic [31:0]      HSPACE32 = 32'd1 << HANDLE_BITS;
    localparam logic [KB_W-1:0]  POOL_RST = pool_kb(NUM_CLASSES, HANDLE_BITS);

    // Request
    func_t                  req_func_reg;
    logic [SIZE_W-1:0]      req_size_reg;
    logic [CLS_W-1:0]       req_class_reg;
    logic [HANDLE_BITS-1:0] req_handle_reg;

    // Class state
    logic [CNT_W-1:0] stack_cnt_reg [CLS_MAX];
    logic [CNT_W-1:0] fresh_reg [CLS_MAX];
    logic [IU_W-1:0]  in_use_reg [CLS_MAX];
    logic [KB_W-1:0]  total_reg;
    logic [KB_W-1:0]  limit_reg;

    logic [HANDLE_BITS-1:0] mem [MEM_DEPTH];
    logic [HANDLE_BITS-1:0] rd_data_reg;

    // Result register
    logic                   out_valid_reg;
    status_t                out_status_reg;
    logic [CLS_W-1:0]       out_class_reg;
    logic [PORT_HDL_W-1:0]  out_handle_reg;
    logic [PORT_USE_W-1:0]  out_in_use_reg;
    logic [KB_W-1:0]        out_total_reg;

    // Decision
    logic [CLS_W-1:0]       sel_cls;
    logic                   found;
    logic [CLS_W-1:0]       cls;
    logic [CNT_W-1:0]       cnt;
    logic [CNT_W-1:0]       nf;
    logic [IU_W-1:0]        iu;
    logic [31:0]            kb;
    logic [31:0]            pre_lim;
    logic                   do_pop;
    logic                   do_push;
    logic                   do_fresh;
    logic                   charge;
    logic                   iu_inc;
    logic                   iu_dec;
    status_t                res_status;
    logic [CLS_W-1:0]       res_class;
    logic [HANDLE_BITS-1:0] res_handle;
    logic [IU_W-1:0]        res_in_use;
    logic [CNT_W-1:0]       cnt_m1;
    logic [MEM_AW-1:0]      mem_addr;
    logic                   load_res;

    always_comb
    begin
        sel_cls = '0;
        found   = 1'b0;
        for (int c = 0; c < CLS_MAX; c++)
        begin
            if (!found && c < NUM_CLASSES && req_size_reg <= (CLASS_KB[c] << 10))
            begin
                sel_cls = CLS_W'(c);
                found   = 1'b1;
            end
        end
    end

    always_comb
    begin
        cls     = (req_func_reg == FUNC_REL) ? req_class_reg : sel_cls;
        cnt     = stack_cnt_reg[cls];
        nf      = fresh_reg[cls];
        iu      = in_use_reg[cls];
        kb      = CLASS_KB[cls];
        pre_lim = (CLASS_PRE[cls] > HSPACE32) ? HSPACE32 : CLASS_PRE[cls];
        cnt_m1  = cnt - CNT_W'(1);

        res_status = ST_OK;
        res_class  = cls;
        res_handle = '0;
        res_in_use = iu;
        do_pop     = 1'b0;
        do_push    = 1'b0;
        do_fresh   = 1'b0;
        charge     = 1'b0;
        iu_inc     = 1'b0;
        iu_dec     = 1'b0;

        if (req_func_reg == FUNC_ALLOC)
        begin
            if (!found)
            begin
                res_status = ST_TOO_LARGE;
                res_class  = '0;
                res_in_use = '0;
            end
            else if (cnt != '0)
            begin
                do_pop = 1'b1;
                iu_inc = 1'b1;
            end
            else if (32'(nf) < pre_lim)
            begin
                do_fresh   = 1'b1;
                iu_inc     = 1'b1;
                res_handle = nf[HANDLE_BITS-1:0];
            end
            else if (nf == HSPACE)
            begin
                res_status = ST_EXHAUSTED;
            end
            else if ({1'b0, total_reg} + {1'b0, kb} >= {1'b0, limit_reg})
            begin
                res_status = ST_LIMIT;
            end
            else
            begin
                do_fresh   = 1'b1;
                charge     = 1'b1;
                iu_inc     = 1'b1;
                res_handle = nf[HANDLE_BITS-1:0];
            end
        end
        else
        begin
            if ({1'b0, req_class_reg} >= 4'(NUM_CLASSES))
            begin
                res_status = ST_UNKNOWN;
                res_class  = '0;
                res_in_use = '0;
            end
            else
            begin
                iu_dec     = (iu != '0);
                do_push    = (cnt != HSPACE);
                res_handle = req_handle_reg;
            end
        end

        if (iu_inc)
            res_in_use = iu + IU_W'(1);
        else if (iu_dec)
            res_in_use = iu - IU_W'(1);

        mem_addr = {cls[CLS_AW-1:0],
                    do_push ? cnt[HANDLE_BITS-1:0] : cnt_m1[HANDLE_BITS-1:0]};
        load_res = cmd.exec && !do_pop;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            req_func_reg   <= func_t'(in_func);
            req_size_reg   <= in_size;
            req_class_reg  <= in_class;
            req_handle_reg <= HANDLE_BITS'(in_handle);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int c = 0; c < CLS_MAX; c++)
            begin
                stack_cnt_reg[c] <= '0;
                fresh_reg[c]     <= '0;
                in_use_reg[c]    <= '0;
            end
            total_reg <= POOL_RST;
            limit_reg <= LIMIT_RST;
        end
        else
        begin
            if (cfg_we)
                limit_reg <= cfg_wdata;
            if (cmd.exec)
            begin
                if (do_pop)
                    stack_cnt_reg[cls] <= cnt_m1;
                else if (do_push)
                    stack_cnt_reg[cls] <= cnt + CNT_W'(1);
                if (do_fresh)
                    fresh_reg[cls] <= nf + CNT_W'(1);
                if (iu_inc || iu_dec)
                    in_use_reg[cls] <= res_in_use;
                if (charge)
                    total_reg <= total_reg + kb;
            end
        end
    end

    // Free stacks: one port, write on release, read on pop
    always_ff @(posedge clk)
    begin
        if (cmd.exec && do_push)
            mem[mem_addr] <= req_handle_reg;
        if (cmd.exec && do_pop)
            rd_data_reg <= mem[mem_addr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (load_res || cmd.load_pop)
            out_valid_reg <= 1'b1;
        else if (out_ready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (load_res)
        begin
            out_status_reg <= res_status;
            out_class_reg  <= res_class;
            out_handle_reg <= PORT_HDL_W'(res_handle);
            out_in_use_reg <= PORT_USE_W'(res_in_use);
            out_total_reg  <= total_reg + (charge ? kb : 32'd0);
        end
        else if (cmd.load_pop)
        begin
            // count was already bumped when the pop was issued
            out_status_reg <= ST_OK;
            out_class_reg  <= cls;
            out_handle_reg <= PORT_HDL_W'(rd_data_reg);
            out_in_use_reg <= PORT_USE_W'(iu);
            out_total_reg  <= total_reg;
        end
    end

    assign stat.is_pop   = do_pop;
    assign stat.out_free = !out_valid_reg || out_ready;

    assign out_valid  = out_valid_reg;
    assign out_status = out_status_reg;
    assign out_class  = out_class_reg;
    assign out_handle = out_handle_reg;
    assign out_in_use = out_in_use_reg;
    assign out_total  = out_total_reg;

endmodule

`default_nettype wire

### rtl/core/size_class_buffer_allocator.sv
// ----------------------------------------------------------------------------
// size_class_buffer_allocator
// Segregated free-list buffer pool with seven size classes (4K to 8M).
//
//  Channel   Handshake            Contents (lowest bits first)
//  s_*       s_tvalid / s_tready  tuser: func; tdata: req_size, rel_class,
//                                 rel_handle
//  m_*       m_tvalid / m_tready  tuser: status; tdata: buf_class,
//                                 buf_handle, class_in_use, total_kb
//  cfg_*     cfg_we               cfg_wdata: mem_limit_kb
//
// A request passes through accept and decide, and a further pop step when it pops a free stack:
// the single-port stack memory has a registered read.
// One request is in flight at a time; a finished result waits in the output
// register and holds the decide step while m_tready is low.
// Reset clears the class counters, sets the charged total to the
// preallocated pool and the limit to 4194304 KB; the stack memory is not
// cleared, and only entries below a stack's count are ever read.
// ----------------------------------------------------------------------------
`default_nettype none

module size_class_buffer_allocator
    import sca_pkg::*;
#(
    parameter int NUM_CLASSES = 7,
    parameter int HANDLE_BITS = 16
)
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [55:0] s_tdata,   // req_size[31:0], rel_class[34:32], rel_handle[50:35]
    input  wire logic        s_tuser,   // func
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [71:0]      m_tdata,   // buf_class[2:0], buf_handle[18:3],
                                        // class_in_use[35:19], total_kb[67:36]
    output logic [2:0]       m_tuser,   // status
    input  wire logic        cfg_we,
    input  wire logic [31:0] cfg_wdata  // mem_limit_kb
);

    ctrl_cmd_t              cmd;
    dp_stat_t               stat;
    status_t                out_status;
    logic [CLS_W-1:0]       out_class;
    logic [PORT_HDL_W-1:0]  out_handle;
    logic [PORT_USE_W-1:0]  out_in_use;
    logic [KB_W-1:0]        out_total;

    sca_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .cmd      (cmd),
        .stat     (stat)
    );

    sca_datapath #(
        .NUM_CLASSES (NUM_CLASSES),
        .HANDLE_BITS (HANDLE_BITS)
    ) u_datapath (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .stat       (stat),
        .cfg_we     (cfg_we),
        .cfg_wdata  (cfg_wdata),
        .in_func    (s_tuser),
        .in_size    (s_tdata[31:0]),
        .in_class   (s_tdata[34:32]),
        .in_handle  (s_tdata[50:35]),
        .out_valid  (m_tvalid),
        .out_ready  (m_tready),
        .out_status (out_status),
        .out_class  (out_class),
        .out_handle (out_handle),
        .out_in_use (out_in_use),
        .out_total  (out_total)
    );

    assign m_tuser = out_status;
    assign m_tdata = {4'b0, out_total, out_in_use, out_handle, out_class};

    // One request at a time: no accept straight after an accept
    assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("request accepted while previous one in flight");

    // Refused size or unknown class carries no class, handle or count
    assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && (m_tuser == ST_TOO_LARGE || m_tuser == ST_UNKNOWN))
        |-> (m_tdata[35:0] == 36'd0))
        else $error("refused request carries class or handle");

    // Limit or exhaustion hands out no handle
    assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && (m_tuser == ST_LIMIT || m_tuser == ST_EXHAUSTED))
        |-> (m_tdata[18:3] == 16'd0))
        else $error("failed allocation carries a handle");

    // A pop is always followed by its memory read completion
    assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.exec && stat.is_pop) |=> (cmd.load_pop || !stat.out_free))
        else $error("pop not completed after stack read");

endmodule

`default_nettype wire

### bench/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the size-class buffer allocator. A scoreboard
// class predicts every result from the requests accepted on the slave side
// and compares each result on the master side with the oldest prediction.
// Directed requests cover class boundaries and refusals. A bulk phase runs
// the 8M class past its preallocated handles into the memory limit and then
// releases into its free stack.
// Random phases under several memory limits mix matched allocate/release
// pairs with noise. Both sides idle at random.
// ----------------------------------------------------------------------------
module tb_top;
    import sca_pkg::*;

    localparam int          NUM_CLS     = 7;
    localparam int          HDL_BITS    = 16;
    localparam int          HSPACE      = 1 << HDL_BITS;
    localparam int          RUN_LIMIT   = 4000000;
    localparam int          SETTLE      = 8;
    localparam int          PHASE_REQS  = 250;
    localparam int          MAX_REPORTS = 10;
    localparam logic [31:0] LIMIT_MAX   = 32'hFFFF_FFFF;

    typedef struct {
        func_t       func;
        logic [31:0] size;
        logic [2:0]  rel_class;
        logic [15:0] rel_handle;
    } buf_req_t;

    typedef struct {
        status_t     status;
        logic [2:0]  cls;
        logic [15:0] handle;
        logic [16:0] in_use;
        logic [31:0] total;
    } buf_resp_t;

    class pool_scoreboard;
        bit [15:0]   free_stack [NUM_CLS][HSPACE];
        int unsigned stack_depth [NUM_CLS];
        int unsigned next_fresh [NUM_CLS];
        int unsigned in_use [NUM_CLS];
        logic [31:0] charged_kb;
        logic [31:0] limit_kb;
        buf_resp_t   awaited [$];
        int          failures;

        function int unsigned prealloc(int c);
            return (CLASS_PRE[c] > HSPACE) ? HSPACE : CLASS_PRE[c];
        endfunction

        function void clear();
            charged_kb = '0;
            for (int c = 0; c < NUM_CLS; c++)
            begin
                stack_depth[c] = 0;
                next_fresh[c]  = 0;
                in_use[c]      = 0;
                charged_kb     = charged_kb + prealloc(c) * CLASS_KB[c];
            end
            limit_kb = LIMIT_RST;
            failures = 0;
        endfunction

        function buf_resp_t note_request(buf_req_t r);
            buf_resp_t   res;
            int          c;
            logic [15:0] h;
            res.status = ST_OK;
            res.cls    = '0;
            res.handle = '0;
            res.in_use = '0;
            h          = '0;
            if (r.func == FUNC_ALLOC)
            begin
                c = 0;
                while (c < NUM_CLS && 64'(r.size) > 64'(CLASS_KB[c]) * 64'd1024)
                    c++;
                if (c == NUM_CLS)
                    res.status = ST_TOO_LARGE;
                else
                begin
                    res.cls = 3'(c);
                    if (stack_depth[c] > 0)
                    begin
                        stack_depth[c]--;
                        h = free_stack[c][stack_depth[c]];
                    end
                    else if (next_fresh[c] < prealloc(c))
                    begin
                        h = 16'(next_fresh[c]);
                        next_fresh[c]++;
                    end
                    else if (next_fresh[c] >= HSPACE)
                        res.status = ST_EXHAUSTED;
                    else if (64'(charged_kb) + 64'(CLASS_KB[c]) >= 64'(limit_kb))
                        res.status = ST_LIMIT;
                    else
                    begin
                        charged_kb = charged_kb + CLASS_KB[c];
                        h = 16'(next_fresh[c]);
                        next_fresh[c]++;
                    end
                    if (res.status == ST_OK)
                    begin
                        in_use[c]++;
                        res.handle = h;
                    end
                    res.in_use = 17'(in_use[c]);
                end
            end
            else if (r.rel_class >= NUM_CLS)
                res.status = ST_UNKNOWN;
            else
            begin
                c = int'(r.rel_class);
                if (in_use[c] > 0)
                    in_use[c]--;
                // drop the push once the stack holds the whole handle space
                if (stack_depth[c] < HSPACE)
                begin
                    free_stack[c][stack_depth[c]] = r.rel_handle;
                    stack_depth[c]++;
                end
                res.cls    = r.rel_class;
                res.handle = r.rel_handle;
                res.in_use = 17'(in_use[c]);
            end
            res.total = charged_kb;
            awaited.push_back(res);
            return res;
        endfunction

        function void check_result(buf_resp_t got);
            buf_resp_t want;
            if (awaited.size() == 0)
            begin
                failures++;
                if (failures <= MAX_REPORTS)
                    $display("unexpected result: st %0d cls %0d hdl %0d use %0d kb %0d",
                             got.status, got.cls, got.handle, got.in_use, got.total);
                return;
            end
            want = awaited.pop_front();
            if (got.status !== want.status || got.cls !== want.cls ||
                got.handle !== want.handle || got.in_use !== want.in_use ||
                got.total !== want.total)
            begin
                failures++;
                if (failures <= MAX_REPORTS)
                begin
                    $display("mismatch: expected st %0d cls %0d hdl %0d use %0d kb %0d",
                             want.status, want.cls, want.handle, want.in_use, want.total);
                    $display("          got      st %0d cls %0d hdl %0d use %0d kb %0d",
                             got.status, got.cls, got.handle, got.in_use, got.total);
                end
            end
        endfunction
    endclass

    logic        clk;
    logic        rst_n     = 1'b0;
    logic        s_tvalid  = 1'b0;
    logic        s_tready;
    logic [55:0] s_tdata   = '0;   // req_size, rel_class, rel_handle
    logic        s_tuser   = 1'b0; // func
    logic        m_tvalid;
    logic        m_tready  = 1'b0;
    logic [71:0] m_tdata;          // buf_class, buf_handle, class_in_use, total_kb
    logic [2:0]  m_tuser;          // status
    logic        cfg_we    = 1'b0;
    logic [31:0] cfg_wdata = '0;

    pool_scoreboard sb;
    logic [18:0]    live [$];      // {class, handle} of buffers still held
    bit             quiet;
    int             burst_left;
    int             hold_left;

    size_class_buffer_allocator #(
        .NUM_CLASSES (NUM_CLS),
        .HANDLE_BITS (HDL_BITS)
    ) i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Result side: check what the edge accepts, then move along the stall pattern
    always @(posedge clk)
    begin
        buf_resp_t seen;
        if (rst_n && m_tvalid && m_tready)
        begin
            seen.status = status_t'(m_tuser);
            seen.cls    = m_tdata[2:0];
            seen.handle = m_tdata[18:3];
            seen.in_use = m_tdata[35:19];
            seen.total  = m_tdata[67:36];
            sb.check_result(seen);
        end
        if (quiet)
            m_tready <= 1'b1;
        else if (hold_left > 0)
            hold_left--;
        else
        begin
            m_tready  <= ~m_tready;
            hold_left = m_tready ? $urandom_range(0, 7) : $urandom_range(0, 24);
        end
    end

    initial
    begin
        repeat (RUN_LIMIT) @(posedge clk);
        $display("status: fail");
        $finish;
    end

    task automatic send_request(buf_req_t r);
        buf_resp_t want;
        s_tvalid <= 1'b1;
        s_tuser  <= r.func;
        s_tdata  <= {5'd0, r.rel_handle, r.rel_class, r.size};
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        want = sb.note_request(r);
        if (r.func == FUNC_ALLOC && want.status == ST_OK)
            live.push_back({want.cls, want.handle});
        if (burst_left > 0)
            burst_left--;
        else
        begin
            burst_left = $urandom_range(0, 15);
            if (!quiet)
            begin
                s_tvalid <= 1'b0;
                repeat ($urandom_range(1, 6)) @(posedge clk);
            end
        end
    endtask

    task automatic send_alloc(logic [31:0] bytes);
        buf_req_t r;
        r.func       = FUNC_ALLOC;
        r.size       = bytes;
        r.rel_class  = 3'($urandom);
        r.rel_handle = 16'($urandom);
        send_request(r);
    endtask

    task automatic send_release(logic [2:0] cls, logic [15:0] handle);
        buf_req_t r;
        r.func       = FUNC_REL;
        r.size       = $urandom;
        r.rel_class  = cls;
        r.rel_handle = handle;
        send_request(r);
    endtask

    // Hold the sender until every predicted result has been taken
    task automatic drain();
        s_tvalid <= 1'b0;
        while (sb.awaited.size() != 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    task automatic set_limit(logic [31:0] kb);
        drain();
        cfg_we    <= 1'b1;
        cfg_wdata <= kb;
        @(posedge clk);
        sb.limit_kb = kb;
        cfg_we    <= 1'b0;
    endtask

    function automatic buf_req_t random_request();
        buf_req_t    r;
        int          pick;
        int          c;
        int          idx;
        logic [31:0] lo;
        logic [31:0] hi;
        r.func       = FUNC_ALLOC;
        r.size       = $urandom;
        r.rel_class  = 3'($urandom_range(0, 7));
        r.rel_handle = 16'($urandom);
        pick         = $urandom_range(0, 99);
        if (pick < 45)
        begin
            // size inside one class or above the largest, class edges favoured
            c  = $urandom_range(0, NUM_CLS);
            lo = 32'd0;
            hi = LIMIT_MAX;
            if (c > 0)
                lo = CLASS_KB[c-1] * 32'd1024 + 32'd1;
            if (c < NUM_CLS)
                hi = CLASS_KB[c] * 32'd1024;
            case ($urandom_range(0, 3))
                0:       r.size = lo;
                1:       r.size = hi;
                default: r.size = $urandom_range(hi, lo);
            endcase
        end
        else if (pick < 85 && live.size() > 0)
        begin
            idx          = $urandom_range(0, live.size() - 1);
            r.func       = FUNC_REL;
            r.rel_class  = live[idx][18:16];
            r.rel_handle = live[idx][15:0];
            live.delete(idx);
        end
        else if (pick < 92)
            r.func = FUNC_REL;
        return r;
    endfunction

    initial
    begin
        int          n;
        logic [31:0] lim;
        sb = new();
        sb.clear();
        quiet      = 1'b0;
        burst_left = 0;
        hold_left  = 0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // class boundaries, refusals and release corner cases
        send_alloc(32'd0);
        send_alloc(32'd4096);
        send_alloc(32'd4097);
        send_alloc(32'd16384);
        send_alloc(32'd16385);
        send_alloc(32'd65536);
        send_alloc(32'd262144);
        send_alloc(32'd262145);
        send_alloc(32'd1048576);
        send_alloc(32'd1048577);
        send_alloc(32'd4194304);
        send_alloc(32'd4194305);
        send_alloc(32'd8388608);
        send_alloc(32'd8388609);
        send_alloc(LIMIT_MAX);
        send_release(3'd7, 16'hFFFF);
        send_release(3'd0, 16'hFFFF);
        send_alloc(32'd1);
        send_release(3'd6, 16'h0000);
        send_release(3'd6, 16'h5A5A);
        send_release(3'd6, 16'hA5A5);
        send_alloc(32'd8388608);
        send_release(3'd5, 16'h0001);

        // run the 8M class past its preallocated handles: four fresh
        // buffers fit under the limit, the rest are refused
        set_limit(sb.charged_kb + 32'd40960);
        quiet = 1'b1;
        n = int'(sb.stack_depth[NUM_CLS-1] + sb.prealloc(NUM_CLS-1)
                 - sb.next_fresh[NUM_CLS-1]) + 6;
        repeat (n) send_alloc($urandom_range(32'd8388608, 32'd4194305));
        drain();
        repeat (16) send_release(3'(NUM_CLS - 1), 16'($urandom));
        drain();
        live.delete();
        quiet = 1'b0;

        for (int phase = 0; phase < 5; phase++)
        begin
            drain();
            case (phase)
                0:       lim = 32'd0;
                1:       lim = sb.charged_kb + 32'd20000;
                2:       lim = LIMIT_RST;
                3:       lim = $urandom;
                default: lim = LIMIT_MAX;
            endcase
            set_limit(lim);
            for (int i = 0; i < PHASE_REQS; i++)
            begin
                if (i % 50 == 0)
                    quiet = ($urandom_range(0, 3) == 0);
                if (i == PHASE_REQS / 2)
                    drain();
                send_request(random_request());
            end
        end

        drain();
        if (sb.failures == 0 && sb.awaited.size() == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule

### files.f
rtl/core/sca_pkg.sv
rtl/core/sca_ctrl.sv
rtl/core/sca_datapath.sv
rtl/core/size_class_buffer_allocator.sv
bench/tb_top.sv
